FILE: hw/rtl/mps_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the marker persistence selector.
// No dependencies; imported by every module of the block.
package mps_pkg;

  localparam int MAX_IDS   = 1024;
  localparam int MAX_DETS  = 16;
  localparam int HIST_MAX  = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam int ID_W      = 10;
  localparam int AREA_W    = 21;
  localparam int LEN_W     = 6;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;
  localparam int IDX_W     = $clog2(MAX_IDS);
  localparam int DET_IDX_W = $clog2(MAX_DETS);
  localparam int CNT_W     = $clog2(MAX_DETS + 1);
  localparam int ONES_W    = $clog2(HIST_MAX + 1);
  localparam int PROD_W    = 13;
  localparam int PCT_SCALE = 100;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_PCT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_ENABLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_ID       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZED_A       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZED_B       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZED_C       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZED_D       = 3'd7;

  localparam logic [LEN_W-1:0] HISTORY_LEN_RESET = 6'd15;

  // one queued word: a detection or an end-of-frame marker
  typedef struct packed {
    logic              eof;
    logic [ID_W-1:0]   id;
    logic [AREA_W-1:0] area;
  } mps_word_t;

  typedef struct packed {
    logic [LEN_W-1:0]         history_len;
    logic [PCT_W-1:0]         threshold_pct;
    logic                     lock_enable;
    logic [ID_W-1:0]          lock_id;
    logic [3:0][ID_W-1:0]     sized_id;
  } mps_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EVAL,
    ST_DECIDE
  } mps_state_t;

  // window length clamped to the history width
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] r;
    r = (len > LEN_W'(HIST_MAX)) ? LEN_W'(HIST_MAX) : len;
    return r;
  endfunction

  function automatic logic [HIST_MAX-1:0] win_mask(input logic [LEN_W-1:0] n);
    logic [HIST_MAX-1:0] m;
    for (int k = 0; k < HIST_MAX; k++) begin
      m[k] = (LEN_W'(k) < n);
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/marker_persistence_selector.sv
`timescale 1ns / 1ps
// Timing: a detection word passes through the front queue into the detection buffer; a
// frame result is registered after its end-of-frame word has run through the sweep,
// search and decide states, the search covering the buffered detections.
// Throughput: one detection per cycle while the back end is idle; an end of frame holds
// the back end for the history sweep over all MAX_IDS entries and the candidate search.
// Reset: synchronous; histories read as zero, no active marker, registers at defaults.
module marker_persistence_selector import mps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [ID_W-1:0]       marker_num,
  input  logic [AREA_W-1:0]     marker_area,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ID_W-1:0]       active_id,
  output logic                  active_seen,
  output logic                  changed,
  output logic                  overflow,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  mps_cfg_t  cfg;
  logic      q_valid;
  mps_word_t q_word;
  logic      q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.history_len   <= HISTORY_LEN_RESET;
      cfg.threshold_pct <= '0;
      cfg.lock_enable   <= 1'b0;
      cfg.lock_id       <= '0;
      cfg.sized_id      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HISTORY_LEN:   cfg.history_len   <= cfg_data[LEN_W-1:0];
        CFG_THRESHOLD_PCT: cfg.threshold_pct <= cfg_data[PCT_W-1:0];
        CFG_LOCK_ENABLE:   cfg.lock_enable   <= cfg_data[0];
        CFG_LOCK_ID:       cfg.lock_id       <= cfg_data[ID_W-1:0];
        CFG_SIZED_A:       cfg.sized_id[0]   <= cfg_data[ID_W-1:0];
        CFG_SIZED_B:       cfg.sized_id[1]   <= cfg_data[ID_W-1:0];
        CFG_SIZED_C:       cfg.sized_id[2]   <= cfg_data[ID_W-1:0];
        CFG_SIZED_D:       cfg.sized_id[3]   <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  mps_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .marker_num  (marker_num),
    .marker_area (marker_area),
    .q_valid     (q_valid),
    .q_word      (q_word),
    .q_pop       (q_pop)
  );

  mps_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_word       (q_word),
    .q_pop        (q_pop),
    .res_valid    (out_valid),
    .res_ready    (out_ready),
    .res_id       (active_id),
    .res_seen     (active_seen),
    .res_changed  (changed),
    .res_overflow (overflow)
  );

endmodule

FILE: hw/rtl/mps_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words, tags end of frame and queues them.
// Depends on mps_pkg.
module mps_front import mps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [ID_W-1:0]   marker_num,
  input  logic [AREA_W-1:0] marker_area,
  output logic              q_valid,
  output mps_word_t         q_word,
  input  logic              q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  mps_word_t             fifo [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [PTR_W:0]        count;
  logic                  push;
  logic                  pop;
  mps_word_t             in_word;

  // classify the incoming word
  always_comb begin
    in_word.eof  = cmd;
    in_word.id   = marker_num;
    in_word.area = marker_area;
  end

  assign in_ready = (count != (PTR_W+1)'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_word   = fifo[rd_ptr];

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= in_word;
  end

endmodule

FILE: hw/rtl/mps_back.sv
`timescale 1ns / 1ps
// Back end: detection buffer, history table sweep, candidate search, result.
// Depends on mps_pkg.
module mps_back import mps_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  mps_cfg_t        cfg,
  input  logic            q_valid,
  input  mps_word_t       q_word,
  output logic            q_pop,
  output logic            res_valid,
  input  logic            res_ready,
  output logic [ID_W-1:0] res_id,
  output logic            res_seen,
  output logic            res_changed,
  output logic            res_overflow
);

  mps_state_t state, state_next;

  // detection buffer
  logic [ID_W-1:0]     det_id   [MAX_DETS];
  logic [AREA_W-1:0]   det_area [MAX_DETS];
  logic [MAX_DETS-1:0] det_rep;
  logic [CNT_W-1:0]    det_count;
  logic                drop_flag;
  logic [MAX_DETS-1:0] ent_used;

  // history table
  logic [HIST_MAX-1:0] hist_mem [MAX_IDS];
  logic [HIST_MAX-1:0] rd_data;
  logic [IDX_W-1:0]    rd_addr;
  logic [HIST_MAX-1:0] wr_data;
  logic                zero_hist;

  // sweep pipeline
  logic [IDX_W:0]      sweep_cnt;
  logic                sweep_issue;
  logic                p1_valid;
  logic [IDX_W-1:0]    p1_addr;
  logic                sweep_hit;
  logic [HIST_MAX-1:0] old_hist;

  // search pipeline
  logic [CNT_W-1:0]     eval_cnt;
  logic                 eval_issue;
  logic                 e1_valid;
  logic [DET_IDX_W-1:0] e1_idx;
  logic                 e2_valid;
  logic [DET_IDX_W-1:0] e2_idx;
  logic [ONES_W-1:0]    e2_ones;
  logic [PROD_W-1:0]    lhs;
  logic [PROD_W-1:0]    rhs;
  logic                 e2_pass;
  logic                 e2_sized;
  logic                 e2_qual;
  logic [ID_W-1:0]      e2_id;
  logic [AREA_W-1:0]    e2_area;

  logic                best_any_v;
  logic [AREA_W-1:0]   best_any_area;
  logic [ID_W-1:0]     best_any_id;
  logic                best_sz_v;
  logic [AREA_W-1:0]   best_sz_area;
  logic [ID_W-1:0]     best_sz_id;

  logic [ID_W-1:0]     active_reg;
  logic [ID_W-1:0]     dec_act;
  logic                dec_chg;
  logic                dec_seen;

  logic [LEN_W-1:0]    eff;
  logic [HIST_MAX-1:0] mask;

  assign eff  = eff_len(cfg.history_len);
  assign mask = win_mask(eff);

  always_comb begin
    for (int k = 0; k < MAX_DETS; k++) begin
      ent_used[k] = (CNT_W'(k) < det_count);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state and queue pop
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (!q_word.eof) begin
            q_pop = 1'b1;
          end else if (!res_valid) begin
            q_pop      = 1'b1;
            state_next = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (sweep_cnt[IDX_W] && !p1_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (eval_cnt == det_count && !e1_valid && !e2_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sweep: shift the frame bit into every window
  assign sweep_issue = (state == ST_SWEEP) && !sweep_cnt[IDX_W];
  assign eval_issue  = (state == ST_EVAL) && (eval_cnt < det_count);
  assign rd_addr     = (state == ST_SWEEP) ? sweep_cnt[IDX_W-1:0]
                                           : IDX_W'(det_id[eval_cnt[DET_IDX_W-1:0]]);

  always_comb begin
    sweep_hit = 1'b0;
    for (int k = 0; k < MAX_DETS; k++) begin
      if (ent_used[k] && IDX_W'(det_id[k]) == p1_addr) sweep_hit = 1'b1;
    end
  end

  // a pending clear makes the stored word read as zero
  assign old_hist = zero_hist ? '0 : rd_data;
  assign wr_data  = ({old_hist[HIST_MAX-2:0], 1'b0} | HIST_MAX'(sweep_hit)) & mask;

  always_ff @(posedge clk) begin
    if (p1_valid) hist_mem[p1_addr] <= wr_data;
    rd_data <= hist_mem[rd_addr];
  end

  // pass test and size lookup on the second search stage
  assign e2_id   = det_id[e2_idx];
  assign e2_area = det_area[e2_idx];
  assign lhs     = PROD_W'(e2_ones) * PROD_W'(PCT_SCALE);
  assign rhs     = PROD_W'(eff) * PROD_W'(cfg.threshold_pct);
  assign e2_pass = lhs > rhs;

  always_comb begin
    e2_sized = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (cfg.sized_id[k] == e2_id) e2_sized = 1'b1;
    end
    if (e2_id == '0) e2_sized = 1'b0;
  end

  assign e2_qual = e2_valid && det_rep[e2_idx] && e2_pass;

  // frame decision
  always_comb begin
    dec_act  = active_reg;
    dec_chg  = 1'b0;
    dec_seen = 1'b0;
    if (cfg.lock_enable) begin
      dec_act = cfg.lock_id;
    end else if (best_sz_v && best_sz_id != active_reg) begin
      dec_act = best_sz_id;
      dec_chg = 1'b1;
    end
    if (dec_act == '0 && best_any_v) begin
      dec_act = best_any_id;
      dec_chg = 1'b1;
    end
    for (int k = 0; k < MAX_DETS; k++) begin
      if (ent_used[k] && det_id[k] == dec_act) dec_seen = 1'b1;
    end
    if (dec_act == '0) dec_seen = 1'b0;
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      det_count  <= '0;
      drop_flag  <= 1'b0;
      zero_hist  <= 1'b1;
      sweep_cnt  <= '0;
      p1_valid   <= 1'b0;
      eval_cnt   <= '0;
      e1_valid   <= 1'b0;
      e2_valid   <= 1'b0;
      best_any_v <= 1'b0;
      best_sz_v  <= 1'b0;
      active_reg <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;

      // buffer a detection, later equal area supersedes earlier ones
      if (state == ST_IDLE && q_pop && !q_word.eof) begin
        if (det_count != CNT_W'(MAX_DETS)) begin
          det_id[det_count[DET_IDX_W-1:0]]   <= q_word.id;
          det_area[det_count[DET_IDX_W-1:0]] <= q_word.area;
          for (int k = 0; k < MAX_DETS; k++) begin
            if (ent_used[k] && det_area[k] == q_word.area) det_rep[k] <= 1'b0;
          end
          det_rep[det_count[DET_IDX_W-1:0]] <= 1'b1;
          det_count <= det_count + 1'b1;
        end else begin
          drop_flag <= 1'b1;
        end
      end

      if (state == ST_IDLE && q_pop && q_word.eof) sweep_cnt <= '0;

      p1_valid <= sweep_issue;
      if (sweep_issue) begin
        p1_addr   <= sweep_cnt[IDX_W-1:0];
        sweep_cnt <= sweep_cnt + 1'b1;
      end
      if (state == ST_SWEEP && state_next == ST_EVAL) begin
        zero_hist <= 1'b0;
        eval_cnt  <= '0;
      end

      e1_valid <= eval_issue;
      e1_idx   <= eval_cnt[DET_IDX_W-1:0];
      if (eval_issue) eval_cnt <= eval_cnt + 1'b1;
      e2_valid <= e1_valid;
      e2_idx   <= e1_idx;
      e2_ones  <= ONES_W'($countones(rd_data & mask));

      // keep the smallest qualifying area, overall and among sized ids
      if (e2_qual) begin
        if (!best_any_v || e2_area < best_any_area) begin
          best_any_v    <= 1'b1;
          best_any_area <= e2_area;
          best_any_id   <= e2_id;
        end
        if (e2_sized && (!best_sz_v || e2_area < best_sz_area)) begin
          best_sz_v    <= 1'b1;
          best_sz_area <= e2_area;
          best_sz_id   <= e2_id;
        end
      end

      if (state == ST_DECIDE) begin
        active_reg   <= dec_act;
        if (dec_chg) zero_hist <= 1'b1;
        res_valid    <= 1'b1;
        res_id       <= dec_act;
        res_seen     <= dec_seen;
        res_changed  <= dec_chg;
        res_overflow <= drop_flag;
        det_count    <= '0;
        drop_flag    <= 1'b0;
        best_any_v   <= 1'b0;
        best_sz_v    <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/mps_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the marker persistence selector, bound to the top level.
// Depends on mps_pkg.
module mps_checker import mps_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  cmd,
  input logic [ID_W-1:0]       marker_num,
  input logic [AREA_W-1:0]     marker_area,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [ID_W-1:0]       active_id,
  input logic                  active_seen,
  input logic                  changed,
  input logic                  overflow,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(active_id) && $stable(changed) &&
      $stable(active_seen) && $stable(overflow))
    else $error("result word changed while stalled");

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(cmd) && $stable(marker_num) &&
      $stable(marker_area))
    else $error("input word changed while stalled");

  // seen only makes sense for a real marker
  a_seen: assert property (@(posedge clk) disable iff (rst)
    out_valid && active_seen |-> active_id != '0)
    else $error("active_seen with no active marker");

  // register writes only while no input word is offered
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> !in_valid && !$isunknown({cfg_index, cfg_data}))
    else $error("register write with an input word pending");

  // reset drops any pending result
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind marker_persistence_selector mps_checker u_mps_checker (.*);

FILE: tb/sv/marker_persistence_selector_test.sv
`timescale 1ns / 1ps
// Self-checking bench for marker_persistence_selector: directed table, then random frames
// under several register settings and handshake idling patterns, checked by a local predictor.
// Depends on mps_pkg and the marker_persistence_selector RTL.
module marker_persistence_selector_test;
  import mps_pkg::*;

  localparam logic CMD_DET = 1'b0;
  localparam logic CMD_EOF = 1'b1;
  localparam int   CYCLE_LIMIT = 8000000;
  localparam int   DRAIN_CYCLES = MAX_IDS + MAX_DETS + 64;
  localparam int   RAND_WORDS = 1300;
  localparam int   N_SETTINGS = 8;
  localparam int   N_ROWS = 13;

  typedef struct packed {
    logic [ID_W-1:0] active_id;
    logic            active_seen;
    logic            changed;
    logic            overflow;
  } frame_result_t;

  typedef struct {
    logic            cmd;
    logic [ID_W-1:0] id;
    logic [AREA_W-1:0] area;
    int              reps;
    bit              typed;
    frame_result_t   res;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  cmd;
  logic [ID_W-1:0]       marker_num;
  logic [AREA_W-1:0]     marker_area;
  logic                  out_valid;
  logic                  out_ready;
  logic [ID_W-1:0]       active_id;
  logic                  active_seen;
  logic                  changed;
  logic                  overflow;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  marker_persistence_selector u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .marker_num(marker_num), .marker_area(marker_area),
    .out_valid(out_valid), .out_ready(out_ready),
    .active_id(active_id), .active_seen(active_seen),
    .changed(changed), .overflow(overflow),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [LEN_W-1:0]  p_len;
  logic [PCT_W-1:0]  p_pct;
  logic              p_lock_en;
  logic [ID_W-1:0]   p_lock_id;
  logic [ID_W-1:0]   p_sized [4];
  logic [31:0]       p_hist [MAX_IDS];
  logic [ID_W-1:0]   p_det_id [MAX_DETS];
  logic [AREA_W-1:0] p_det_area [MAX_DETS];
  int                p_count;
  logic              p_drop;
  logic [ID_W-1:0]   p_active;

  frame_result_t pending_frames[$];
  int  in_idle;
  int  out_idle;
  int  cycles;
  bit  failed;

  // clock and watchdog
  initial begin
    clk = 1'b0;
    cycles = 0;
    forever begin
      #5 clk = ~clk;
      if (clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  function automatic int eff_window();
    return (p_len > LEN_W'(HIST_MAX)) ? HIST_MAX : int'(p_len);
  endfunction

  function automatic logic [31:0] window_mask();
    int n;
    n = eff_window();
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
  endfunction

  function automatic bit persists(input logic [ID_W-1:0] id);
    int ones;
    ones = $countones(p_hist[id] & window_mask());
    return ones * PCT_SCALE > eff_window() * int'(p_pct);
  endfunction

  function automatic bit is_sized(input logic [ID_W-1:0] id);
    if (id == '0) return 1'b0;
    foreach (p_sized[k]) if (p_sized[k] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void clear_histories();
    foreach (p_hist[k]) p_hist[k] = '0;
  endfunction

  function automatic void predictor_reset();
    p_len = HISTORY_LEN_RESET;
    p_pct = '0;
    p_lock_en = 1'b0;
    p_lock_id = '0;
    foreach (p_sized[k]) p_sized[k] = '0;
    clear_histories();
    p_count = 0;
    p_drop = 1'b0;
    p_active = '0;
  endfunction

  // one accepted word; an end of frame queues the predicted result
  function automatic void predict_word(input logic c, input logic [ID_W-1:0] id,
                                       input logic [AREA_W-1:0] area);
    logic [AREA_W-1:0] ua [MAX_DETS];
    logic [ID_W-1:0]   ui [MAX_DETS];
    logic [AREA_W-1:0] a;
    logic [ID_W-1:0]   d;
    logic [31:0]       m;
    int                n;
    int                j;
    bit                hit;
    frame_result_t     r;
    if (c == CMD_DET) begin
      if (p_count < MAX_DETS) begin
        p_det_id[p_count] = id;
        p_det_area[p_count] = area;
        p_count++;
      end else begin
        p_drop = 1'b1;
      end
      return;
    end
    // unique areas, later equal area wins, then ascending order
    n = 0;
    for (int i = 0; i < p_count; i++) begin
      hit = 1'b0;
      for (j = 0; j < n; j++) begin
        if (!hit && ua[j] == p_det_area[i]) begin
          ui[j] = p_det_id[i];
          hit = 1'b1;
        end
      end
      if (!hit) begin
        ua[n] = p_det_area[i];
        ui[n] = p_det_id[i];
        n++;
      end
    end
    for (int i = 1; i < n; i++) begin
      a = ua[i];
      d = ui[i];
      j = i;
      while (j > 0 && ua[j-1] > a) begin
        ua[j] = ua[j-1];
        ui[j] = ui[j-1];
        j--;
      end
      ua[j] = a;
      ui[j] = d;
    end
    // shift this frame into every window
    m = window_mask();
    foreach (p_hist[k]) p_hist[k] = (p_hist[k] << 1) & m;
    for (int i = 0; i < p_count; i++) p_hist[p_det_id[i]] |= 32'd1 & m;
    r = '0;
    if (p_lock_en) begin
      p_active = p_lock_id;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (is_sized(ui[i]) && persists(ui[i])) begin
          if (p_active != ui[i]) begin
            p_active = ui[i];
            clear_histories();
            r.changed = 1'b1;
          end
          break;
        end
      end
    end
    // fallback: any persistent marker
    if (p_active == '0) begin
      for (int i = 0; i < n; i++) begin
        if (persists(ui[i])) begin
          p_active = ui[i];
          clear_histories();
          r.changed = 1'b1;
          break;
        end
      end
    end
    if (p_active != '0)
      for (int i = 0; i < p_count; i++)
        if (p_det_id[i] == p_active) r.active_seen = 1'b1;
    r.active_id = p_active;
    r.overflow = p_drop;
    pending_frames.insert(pending_frames.size(), r);
    p_count = 0;
    p_drop = 1'b0;
  endfunction

  // register write, mirrored into the predictor; the caller drops cfg_we
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    case (idx)
      CFG_HISTORY_LEN:   p_len = LEN_W'(val);
      CFG_THRESHOLD_PCT: p_pct = PCT_W'(val);
      CFG_LOCK_ENABLE:   p_lock_en = val[0];
      CFG_LOCK_ID:       p_lock_id = ID_W'(val);
      CFG_SIZED_A:       p_sized[0] = ID_W'(val);
      CFG_SIZED_B:       p_sized[1] = ID_W'(val);
      CFG_SIZED_C:       p_sized[2] = ID_W'(val);
      CFG_SIZED_D:       p_sized[3] = ID_W'(val);
      default: ;
    endcase
  endtask

  // send one word; valid stays high into the next word when no gap is drawn
  task automatic send_word(input logic c, input logic [ID_W-1:0] id,
                           input logic [AREA_W-1:0] area);
    while ($urandom_range(99) < in_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    marker_num <= id;
    marker_area <= area;
    do @(posedge clk); while (!in_ready);
    predict_word(c, id, area);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls and in-order compare
  initial begin
    frame_result_t e;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_frames.size() == 0) begin
          $error("unexpected result word: active_id %0d", active_id);
          failed = 1'b1;
        end else begin
          e = pending_frames.pop_front();
          if (active_id !== e.active_id) begin
            $error("active_id: expected %0d, got %0d", e.active_id, active_id);
            failed = 1'b1;
          end
          if (active_seen !== e.active_seen) begin
            $error("active_seen: expected %0d, got %0d", e.active_seen, active_seen);
            failed = 1'b1;
          end
          if (changed !== e.changed) begin
            $error("changed: expected %0d, got %0d", e.changed, changed);
            failed = 1'b1;
          end
          if (overflow !== e.overflow) begin
            $error("overflow: expected %0d, got %0d", e.overflow, overflow);
            failed = 1'b1;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= out_idle);
    end
  end

  // stimulus
  initial begin
    stim_row_t rows [N_ROWS];
    int settings [N_SETTINGS][8];
    int frame_len;
    int words;
    logic [ID_W-1:0] id;
    logic [AREA_W-1:0] area;
    frame_result_t zero_res;

    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_DET;
    marker_num = '0;
    marker_area = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_HISTORY_LEN;
    cfg_data = '0;
    failed = 1'b0;
    in_idle = 32;
    out_idle = 58;
    predictor_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; only the empty frame after reset has a typed result
    zero_res = '0;
    rows = '{
      '{CMD_EOF, 10'd0, 21'd0, 1, 1'b1, zero_res},
      '{CMD_DET, 10'd1023, 21'h1FFFFF, 1, 1'b0, zero_res},
      '{CMD_DET, 10'd0, 21'd0, 1, 1'b0, zero_res},
      '{CMD_DET, 10'd7, 21'd0, 1, 1'b0, zero_res},     // equal area replaces
      '{CMD_EOF, 10'd0, 21'd0, 1, 1'b0, zero_res},
      '{CMD_DET, 10'd0, 21'd5, 1, 1'b0, zero_res},     // id zero, marker 7 already active
      '{CMD_EOF, 10'h3FF, 21'h1FFFFF, 1, 1'b0, zero_res},
      '{CMD_DET, 10'd3, 21'd9, 17, 1'b0, zero_res},    // buffer full, one dropped
      '{CMD_EOF, 10'd0, 21'd0, 1, 1'b0, zero_res},
      '{CMD_DET, 10'd7, 21'd40, 1, 1'b0, zero_res},
      '{CMD_DET, 10'd3, 21'd20, 1, 1'b0, zero_res},
      '{CMD_EOF, 10'd0, 21'd0, 1, 1'b0, zero_res},
      '{CMD_EOF, 10'd0, 21'd0, 1, 1'b0, zero_res}
    };
    foreach (rows[r]) begin
      repeat (rows[r].reps) begin
        send_word(rows[r].cmd, rows[r].id, rows[r].area);
        if (rows[r].typed) begin
          // typed row: replace the predicted entry by the literal one
          void'(pending_frames.pop_back());
          pending_frames.insert(pending_frames.size(), rows[r].res);
        end
      end
    end
    wait_idle();

    // len, pct, lock_en, lock_id, sized a..d
    settings = '{
      '{15, 0, 0, 0, 0, 0, 0, 0},
      '{4, 50, 0, 0, 3, 5, 9, 0},
      '{32, 20, 0, 0, 5, 3, 1023, 7},
      '{63, 100, 0, 0, 3, 5, 7, 9},    // window clamped, nothing can exceed 100 percent
      '{0, 0, 1, 0, 1, 2, 3, 4},       // empty window, lock to zero
      '{1, 127, 1, 9, 0, 0, 0, 0},
      '{8, 30, 1, 1023, 2, 4, 6, 8},
      '{2, 0, 0, 0, 1, 2, 3, 1023}
    };

    for (int s = 0; s < N_SETTINGS; s++) begin
      in_idle  = (s < 3) ? 32 : (s < 6) ? 58 : 0;
      out_idle = (s < 3) ? 58 : (s < 6) ? 32 : 0;
      for (int k = 0; k < 8; k++) write_reg(CFG_IDX_W'(k), settings[s][k]);
      cfg_we <= 1'b0;
      words = 0;
      while (words < RAND_WORDS / N_SETTINGS) begin
        case ($urandom_range(19))
          0:       frame_len = 0;
          1, 2:    frame_len = $urandom_range(14, 20);
          default: frame_len = $urandom_range(1, 6);
        endcase
        repeat (frame_len) begin
          if ($urandom_range(9) < 7) begin
            id = ($urandom_range(9) == 0) ? 10'd1023 : ID_W'($urandom_range(0, 9));
          end else begin
            id = ID_W'($urandom);
          end
          area = ($urandom_range(9) < 6) ? AREA_W'($urandom_range(0, 20)) : AREA_W'($urandom);
          send_word(CMD_DET, id, area);
        end
        send_word(CMD_EOF, ID_W'($urandom), AREA_W'($urandom));
        words += frame_len + 1;
      end
      wait_idle();
    end

    if (!failed && pending_frames.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mps_pkg.sv
hw/rtl/mps_front.sv
hw/rtl/mps_back.sv
hw/rtl/marker_persistence_selector.sv
hw/rtl/mps_checker.sv
tb/sv/marker_persistence_selector_test.sv
